### sv/tmc_pkg.sv
// Package for the tempo map converter: constants, action codes and the search token.
// Used by every module of the block; it depends on nothing.
`timescale 1ns / 1ps

package tmc_pkg;

  // Number of tempo segment cells in the chain.
  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // Fixed field widths.
  localparam int TPQ_W   = 16;
  localparam int COUNT_W = 7;
  localparam int ENTRY_W = 6;
  localparam int POS_W   = 32;
  localparam int TEMPO_W = 16;

  // 60 s/min * 64 (Q10.6 tempo) * 256 (Q24.8 ticks).
  localparam logic [31:0] SCALE_K = 32'd983040;

  // Action codes carried in tuser.
  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_TICK2SEC = 2'd1,
    ACT_SEC2TICK = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam logic REG_TPQ   = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Query token that walks the cell chain, carrying the best segment so far.
  typedef struct packed {
    logic                      valid;
    logic                      tick_to_sec;
    logic signed [POS_W-1:0]   qv;
    logic [POS_W-1:0]          key;
    logic [POS_W-1:0]          other;
    logic [TEMPO_W-1:0]        tempo;
  } tok_t;

endpackage

### sv/tmc_cell.sv
// One tempo segment cell: holds a segment and updates the passing query token.
// Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_cell
  import tmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_W-1:0]     cell_idx,
  input  logic [COUNT_W-1:0]   seg_count,
  input  logic                 wr_en,
  input  logic [ENTRY_W-1:0]   wr_idx,
  input  logic [POS_W-1:0]     wr_tick,
  input  logic [POS_W-1:0]     wr_sec,
  input  logic [TEMPO_W-1:0]   wr_tempo,
  input  tok_t                 tok_in,
  output tok_t                 tok_out
);

  logic [POS_W-1:0]   st_tick;
  logic [POS_W-1:0]   st_sec;
  logic [TEMPO_W-1:0] st_tempo;

  logic [POS_W-1:0]   key;
  logic [POS_W-1:0]   other;
  logic               in_table;
  logic               key_le;
  logic               take;
  tok_t               tok_next;

  // The key depends on the conversion direction.
  assign key   = tok_in.tick_to_sec ? st_tick : st_sec;
  assign other = tok_in.tick_to_sec ? st_sec : st_tick;

  // Unsigned key against signed query, both widened to 33 bits.
  assign key_le   = $signed({1'b0, key}) <= $signed({tok_in.qv[POS_W-1], tok_in.qv});
  assign in_table = int'(cell_idx) < int'(seg_count);
  // The first cell always seeds the token so a query below every key uses it.
  assign take     = (cell_idx == '0) || (in_table && key_le);

  always_comb begin
    tok_next = tok_in;
    if (take) begin
      tok_next.key   = key;
      tok_next.other = other;
      tok_next.tempo = st_tempo;
    end
  end

  // Segment storage, written when the write word addresses this cell.
  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_idx) == int'(cell_idx))) begin
      st_tick  <= wr_tick;
      st_sec   <= wr_sec;
      st_tempo <= wr_tempo;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.tick_to_sec <= tok_next.tick_to_sec;
    tok_out.qv          <= tok_next.qv;
    tok_out.key         <= tok_next.key;
    tok_out.other       <= tok_next.other;
    tok_out.tempo       <= tok_next.tempo;
  end

endmodule

### sv/tmc_chain.sv
// Row of segment cells; a query token enters at cell 0 and leaves after the last cell.
// Depends on tmc_pkg and tmc_cell.
`timescale 1ns / 1ps

module tmc_chain
  import tmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [COUNT_W-1:0]   seg_count,
  input  logic                 wr_en,
  input  logic [ENTRY_W-1:0]   wr_idx,
  input  logic [POS_W-1:0]     wr_tick,
  input  logic [POS_W-1:0]     wr_sec,
  input  logic [TEMPO_W-1:0]   wr_tempo,
  input  tok_t                 tok_in,
  output tok_t                 tok_out
);

  tok_t link [MAX_SEGMENTS+1];

  assign link[0] = tok_in;
  assign tok_out = link[MAX_SEGMENTS];

  // One cell per segment slot.
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    tmc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(g)),
      .seg_count (seg_count),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_tick   (wr_tick),
      .wr_sec    (wr_sec),
      .wr_tempo  (wr_tempo),
      .tok_in    (link[g]),
      .tok_out   (link[g+1])
    );
  end

endmodule

### sv/tmc_convert.sv
// Linear conversion of a query against its segment: split multiply, serial divide,
// floor correction and saturation. Depends on tmc_pkg.
`timescale 1ns / 1ps

module tmc_convert
  import tmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tok_t                tok,
  input  logic [TPQ_W-1:0]    tpq,
  output logic                done,
  output logic [POS_W-1:0]    result
);

  localparam int NUM_W = 66;

  typedef enum logic [2:0] {
    CV_IDLE, CV_PREP, CV_MUL_LO, CV_MUL_HI, CV_SUM, CV_DIV, CV_FIN, CV_SAT
  } cv_state_t;

  cv_state_t             state;
  logic                  tick2sec;
  logic signed [31:0]    qv;
  logic [31:0]           key;
  logic [31:0]           other;
  logic [15:0]           tempo;
  logic                  neg;
  logic [32:0]           mag;
  logic [31:0]           mul;
  logic [31:0]           div;
  logic [47:0]           plo;
  logic [48:0]           phi;
  logic [NUM_W-1:0]      num;
  logic [31:0]           rem;
  logic [6:0]            cnt;
  logic signed [67:0]    qs;

  logic signed [33:0]    d;
  logic [15:0]           tempo_eff;
  logic [31:0]           m;
  logic [32:0]           r2;
  logic                  ge;
  logic [NUM_W-1:0]      qadj;
  logic signed [67:0]    v;

  assign d         = 34'(signed'({qv[31], qv[31], qv})) - 34'(signed'({2'b00, key}));
  assign tempo_eff = (tempo == '0) ? 16'd1 : tempo;
  assign m         = 32'(tempo_eff) * 32'(tpq);

  // One restoring division step.
  assign r2 = {rem, num[NUM_W-1]};
  assign ge = r2 >= {1'b0, div};

  // Round toward minus infinity for a negative distance.
  assign qadj = num + NUM_W'(neg && (rem != '0));
  assign v    = 68'(signed'({36'd0, other})) + qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        CV_IDLE: begin
          if (tok.valid) begin
            tick2sec <= tok.tick_to_sec;
            qv       <= tok.qv;
            key      <= tok.key;
            other    <= tok.other;
            tempo    <= tok.tempo;
            state    <= CV_PREP;
          end
        end
        CV_PREP: begin
          neg   <= d[33];
          mag   <= d[33] ? 33'(-d) : d[32:0];
          mul   <= tick2sec ? SCALE_K : m;
          div   <= tick2sec ? m : SCALE_K;
          state <= CV_MUL_LO;
        end
        CV_MUL_LO: begin
          plo   <= 48'(mag[15:0]) * 48'(mul);
          state <= CV_MUL_HI;
        end
        CV_MUL_HI: begin
          phi   <= 49'(mag[32:16]) * 49'(mul);
          state <= CV_SUM;
        end
        CV_SUM: begin
          num   <= NUM_W'({phi, 16'd0}) + NUM_W'(plo);
          rem   <= '0;
          cnt   <= '0;
          state <= CV_DIV;
        end
        CV_DIV: begin
          rem <= ge ? 32'(r2 - {1'b0, div}) : r2[31:0];
          num <= {num[NUM_W-2:0], ge};
          cnt <= cnt + 7'd1;
          if (cnt == 7'(NUM_W - 1)) begin
            state <= CV_FIN;
          end
        end
        CV_FIN: begin
          qs    <= neg ? -68'(signed'({2'b00, qadj})) : 68'(signed'({2'b00, qadj}));
          state <= CV_SAT;
        end
        CV_SAT: begin
          if (v > 68'sd2147483647) begin
            result <= 32'h7fff_ffff;
          end else if (v < -68'sd2147483648) begin
            result <= 32'h8000_0000;
          end else begin
            result <= v[31:0];
          end
          done  <= 1'b1;
          state <= CV_IDLE;
        end
        default: state <= CV_IDLE;
      endcase
    end
  end

endmodule

### sv/tempo_map_converter.sv
// Tempo map converter. A write word (tuser 0) stores one segment and returns a zero word.
// A query (tuser 1: Q24.8 ticks to Q16.16 seconds, tuser 2: the reverse) walks the row
// of MAX_SEGMENTS segment cells, one cell per cycle, then runs a split multiply and a
// one-bit-per-cycle 66-step division. One word is in work at a time, while a finished
// result may wait on the output. Queries on an empty table or with zero ticks_per_quarter
// return zero with no_tempo set.
`timescale 1ns / 1ps

module tempo_map_converter
  import tmc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // APB configuration port.
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // Input stream.
  input  logic          s_tvalid,
  output logic          s_tready,
  // entry_index[5:0], seg_start_tick[37:6], seg_start_seconds[69:38],
  // seg_tempo[85:70], query_value[117:86], zero fill [119:118]
  input  logic [119:0]  s_tdata,
  // action[1:0]
  input  logic [1:0]    s_tuser,
  // Output stream.
  output logic          m_tvalid,
  input  logic          m_tready,
  // result_value[31:0]
  output logic [31:0]   m_tdata,
  // no_tempo[0]
  output logic [0:0]    m_tuser
);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_DONE} state_t;

  state_t               state;
  logic [TPQ_W-1:0]     tpq;
  logic [COUNT_W-1:0]   seg_count;
  logic [31:0]          pend_val;
  logic                 pend_nt;

  logic                 accept;
  action_t              action;
  logic [ENTRY_W-1:0]   entry_index;
  logic [POS_W-1:0]     seg_start_tick;
  logic [POS_W-1:0]     seg_start_seconds;
  logic [TEMPO_W-1:0]   seg_tempo;
  logic [POS_W-1:0]     query_value;
  logic                 is_query;
  logic                 empty;
  tok_t                 tok_launch;
  tok_t                 tok_done;
  logic                 cv_done;
  logic [POS_W-1:0]     cv_result;
  logic                 cfg_wr;

  // Field unpacking.
  assign action            = action_t'(s_tuser);
  assign entry_index       = s_tdata[5:0];
  assign seg_start_tick    = s_tdata[37:6];
  assign seg_start_seconds = s_tdata[69:38];
  assign seg_tempo         = s_tdata[85:70];
  assign query_value       = s_tdata[117:86];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_query = (action == ACT_TICK2SEC) || (action == ACT_SEC2TICK);
  assign empty    = (seg_count == '0) || (tpq == '0);

  // Launch a search token into the cell row.
  always_comb begin
    tok_launch             = '0;
    tok_launch.valid       = accept && is_query && !empty;
    tok_launch.tick_to_sec = (action == ACT_TICK2SEC);
    tok_launch.qv          = signed'(query_value);
  end

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpq       <= TPQ_W'(480);
      seg_count <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TPQ:   tpq       <= pwdata[TPQ_W-1:0];
        REG_COUNT: seg_count <= pwdata[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TPQ:   prdata = 32'(tpq);
      REG_COUNT: prdata = 32'(seg_count);
      default:   prdata = '0;
    endcase
  end

  tmc_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .seg_count (seg_count),
    .wr_en     (accept && (action == ACT_WRITE)),
    .wr_idx    (entry_index),
    .wr_tick   (seg_start_tick),
    .wr_sec    (seg_start_seconds),
    .wr_tempo  (seg_tempo),
    .tok_in    (tok_launch),
    .tok_out   (tok_done)
  );

  tmc_convert u_convert (
    .clk    (clk),
    .rst    (rst),
    .tok    (tok_done),
    .tpq    (tpq),
    .done   (cv_done),
    .result (cv_result)
  );

  // Control sequence and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pend_val <= '0;
            pend_nt  <= is_query && empty;
            state    <= (is_query && !empty) ? ST_SEARCH : ST_DONE;
          end
        end
        ST_SEARCH: begin
          if (cv_done) begin
            pend_val <= cv_result;
            pend_nt  <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= pend_val;
            m_tuser[0] <= pend_nt;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A token leaves the chain only while its query is outstanding.
  a_tok_in_search: assert property (@(posedge clk) disable iff (rst)
    tok_done.valid |-> state == ST_SEARCH)
    else $error("search token left the chain outside a query");

  // The converter finishes only for an outstanding query.
  a_done_in_search: assert property (@(posedge clk) disable iff (rst)
    cv_done |-> state == ST_SEARCH)
    else $error("conversion finished with no query outstanding");

  // A no_tempo result always carries a zero value.
  a_no_tempo_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tdata == '0)
    else $error("no_tempo word with nonzero value");

  // A result is presented in the cycle after the done state when the output is free.
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !m_tvalid) |=> (m_tvalid && state == ST_IDLE))
    else $error("pending result not loaded into free output");

endmodule
